// File: design/perspective_vertex_project_top_assert.svh
// Assertion macros shared by the perspective projection block.
// Each macro expects clk and rst_n in scope.
`ifndef PERSPECTIVE_VERTEX_PROJECT_TOP_ASSERT_SVH
`define PERSPECTIVE_VERTEX_PROJECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define PVP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define PVP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: design/pvp_pkg.sv
//------------------------------------------------------------------------------
// pvp_pkg
// Shared types and constants of the perspective projection pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pvp_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam int DIV_STEPS = 33;
    localparam int NUM_LANES = 3;

    typedef enum logic [2:0] {
        REG_X_SCALE      = 3'd0,
        REG_Y_SCALE      = 3'd1,
        REG_ASPECT_RATIO = 3'd2,
        REG_NEAR_PLANE   = 3'd3,
        REG_FAR_PLANE    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [30:0] x_scale;
        logic [30:0] y_scale;
        logic [30:0] aspect_ratio;
        logic [30:0] near_plane;
        logic [30:0] far_plane;
    } cfg_t;

    // One division in flight: partial remainder, shifted divisor, quotient so far.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dsr;
        logic [32:0] quo;
    } lane_t;

    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] ovf;
        logic                 depth_en;
        logic                 bad;
        logic                 inv;
    } side_t;

    typedef struct packed {
        lane_t [NUM_LANES-1:0] lane;
        side_t                 side;
    } stage_t;

endpackage

`default_nettype wire

// File: design/pvp_front.sv
//------------------------------------------------------------------------------
// pvp_front
// Products, depth numerator, frustum test and divider setup (two stages).
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [95:0]    in_data,
    input  wire pvp_pkg::cfg_t  cfg,
    output logic                out_valid,
    output pvp_pkg::stage_t     out_stage
);

    logic signed [31:0] x, y, z;
    logic [31:0] mag_x, mag_y;
    logic signed [32:0] z_off;
    logic [32:0] mag_d;
    logic signed [32:0] asp_s, nr_s, fr_s;

    logic        v1_reg, v2_reg;
    logic [63:0] num_reg [pvp_pkg::NUM_LANES];
    logic [31:0] den_reg [pvp_pkg::NUM_LANES];
    pvp_pkg::side_t side1_reg;
    pvp_pkg::side_t side1_next;
    pvp_pkg::stage_t stage2_reg;
    pvp_pkg::stage_t stage2_next;

    always_comb
    begin
        x = $signed(in_data[31:0]);
        y = $signed(in_data[63:32]);
        z = $signed(in_data[95:64]);
        mag_x = x[31] ? 32'(-x) : 32'(x);
        mag_y = y[31] ? 32'(-y) : 32'(y);
        z_off = 33'(z) - $signed({2'b00, cfg.near_plane});
        mag_d = z_off[32] ? 33'(-z_off) : 33'(z_off);
        asp_s = $signed({2'b00, cfg.aspect_ratio});
        nr_s  = $signed({2'b00, cfg.near_plane});
        fr_s  = $signed({2'b00, cfg.far_plane});
        side1_next.neg      = {z_off[32], y[31], x[31]};
        side1_next.ovf      = '0;
        side1_next.depth_en = cfg.far_plane > cfg.near_plane;
        side1_next.bad      = z[31] || (z == 32'sd0);
        side1_next.inv      = (33'(x) > -asp_s) && (33'(x) < asp_s)
                           && (y > -pvp_pkg::ONE) && (y < pvp_pkg::ONE)
                           && (33'(z) > nr_s) && (33'(z) < fr_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= 64'(mag_x) * 64'(cfg.x_scale);
            num_reg[1] <= 64'(mag_y) * 64'(cfg.y_scale);
            num_reg[2] <= 64'(mag_d) << pvp_pkg::FRAC_BITS;
            den_reg[0] <= 32'(z);
            den_reg[1] <= 32'(z);
            den_reg[2] <= {1'b0, cfg.far_plane - cfg.near_plane};
            side1_reg  <= side1_next;
            stage2_reg <= stage2_next;
        end
    end

    // A quotient of 2^33 or more is flagged here; the cells then
    // develop the remaining 33 quotient bits.
    always_comb
    begin
        stage2_next.side = side1_reg;
        for (int i = 0; i < pvp_pkg::NUM_LANES; i++)
        begin
            stage2_next.side.ovf[i] = (num_reg[i] >> 33) >= 64'(den_reg[i]);
            stage2_next.lane[i].rem = num_reg[i];
            stage2_next.lane[i].dsr = 64'(den_reg[i]) << 32;
            stage2_next.lane[i].quo = '0;
        end
    end

    assign out_valid = v2_reg;
    assign out_stage = stage2_reg;

endmodule

`default_nettype wire

// File: design/pvp_div_cell.sv
//------------------------------------------------------------------------------
// pvp_div_cell
// One restoring-division step for each of the three lanes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvp_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pvp_pkg::stage_t in_stage,
    output logic                 out_valid,
    output pvp_pkg::stage_t      out_stage
);

    logic            valid_reg;
    pvp_pkg::stage_t stage_reg;
    pvp_pkg::stage_t stage_next;
    logic            ge;

    always_comb
    begin
        stage_next = in_stage;
        ge = 1'b0;
        for (int i = 0; i < pvp_pkg::NUM_LANES; i++)
        begin
            ge = in_stage.lane[i].rem >= in_stage.lane[i].dsr;
            stage_next.lane[i].rem = ge ? in_stage.lane[i].rem - in_stage.lane[i].dsr
                                        : in_stage.lane[i].rem;
            stage_next.lane[i].dsr = in_stage.lane[i].dsr >> 1;
            stage_next.lane[i].quo = {in_stage.lane[i].quo[31:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

// File: design/pvp_back.sv
//------------------------------------------------------------------------------
// pvp_back
// Sign, saturation, clip-box test, bad-depth zeroing and the output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pvp_pkg::stage_t in_stage,
    output logic                 out_valid,
    output logic [95:0]          out_data,
    output logic [2:0]           out_user
);

    function automatic logic [31:0] sat(input logic [32:0] q, input logic ovf,
                                        input logic neg);
        logic big;
        big = ovf || q[32] || q[31];
        if (neg)
            sat = big ? 32'h8000_0000 : 32'(-q[31:0]);
        else
            sat = big ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    logic signed [31:0] nx, ny, nd;
    logic               inc;
    logic               valid_reg;
    logic [95:0]        data_reg;
    logic [2:0]         user_reg;
    logic [95:0]        data_next;
    logic [2:0]         user_next;

    always_comb
    begin
        nx = $signed(sat(in_stage.lane[0].quo, in_stage.side.ovf[0], in_stage.side.neg[0]));
        ny = $signed(sat(in_stage.lane[1].quo, in_stage.side.ovf[1], in_stage.side.neg[1]));
        nd = in_stage.side.depth_en
           ? $signed(sat(in_stage.lane[2].quo, in_stage.side.ovf[2], in_stage.side.neg[2]))
           : 32'sd0;
        inc = (nx > -pvp_pkg::ONE) && (nx < pvp_pkg::ONE)
           && (ny > -pvp_pkg::ONE) && (ny < pvp_pkg::ONE)
           && (nd > 32'sd0) && (nd < pvp_pkg::ONE);
        if (in_stage.side.bad)
        begin
            data_next = '0;
            user_next = 3'b100;
        end
        else
        begin
            data_next = {nd, ny, nx};
            user_next = {1'b0, inc, in_stage.side.inv};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

`default_nettype wire

// File: design/perspective_vertex_project_top.sv
//------------------------------------------------------------------------------
// perspective_vertex_project_top
// Perspective projection and depth normalization of view-space vertices.
//------------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata: view_x, view_y, view_z
// m_axis    out        tdata: ndc_x, ndc_y, ndc_depth; tuser: flags
// cfg       in         register write: cfg_we, cfg_addr, cfg_wdata
//
// One vertex is taken per cycle while m_axis does not stall; there are two setup
// stages, 33 division cells and one output stage. The whole pipeline advances
// together whenever the output register is empty or being drained, so a
// stall at m_axis holds every stage. Reset clears the stage valid bits
// and loads the default registers.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "perspective_vertex_project_top_assert.svh"

module perspective_vertex_project_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // view_x, view_y, view_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // ndc_x, ndc_y, ndc_depth
    output logic [2:0]       m_tuser,   // in_view_frustum, in_clip_box, bad_depth
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [30:0] cfg_wdata
);

    pvp_pkg::cfg_t   cfg_reg;
    logic            en;
    logic            valid_chain [pvp_pkg::DIV_STEPS+1];
    pvp_pkg::stage_t stage_chain [pvp_pkg::DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_scale      <= 31'd513320;
            cfg_reg.y_scale      <= 31'd256660;
            cfg_reg.aspect_ratio <= 31'd32768;
            cfg_reg.near_plane   <= 31'd65536;
            cfg_reg.far_plane    <= 31'd655360;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pvp_pkg::REG_X_SCALE:      cfg_reg.x_scale      <= cfg_wdata;
                pvp_pkg::REG_Y_SCALE:      cfg_reg.y_scale      <= cfg_wdata;
                pvp_pkg::REG_ASPECT_RATIO: cfg_reg.aspect_ratio <= cfg_wdata;
                pvp_pkg::REG_NEAR_PLANE:   cfg_reg.near_plane   <= cfg_wdata;
                pvp_pkg::REG_FAR_PLANE:    cfg_reg.far_plane    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    pvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .cfg       (cfg_reg),
        .out_valid (valid_chain[0]),
        .out_stage (stage_chain[0])
    );

    for (genvar g = 0; g < pvp_pkg::DIV_STEPS; g++)
    begin : g_cell
        pvp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[g]),
            .in_stage  (stage_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_stage (stage_chain[g+1])
        );
    end

    pvp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_chain[pvp_pkg::DIV_STEPS]),
        .in_stage  (stage_chain[pvp_pkg::DIV_STEPS]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

    // A rejected depth zeroes every other field.
    `PVP_ASSERT_NOW(a_bad_zero, m_tvalid && m_tuser[2], (m_tdata == '0) && (m_tuser[1:0] == 2'b00))
    // Inside the clip box implies a strictly positive depth.
    `PVP_ASSERT_NOW(a_clip_depth, m_tvalid && m_tuser[1], $signed(m_tdata[95:64]) > 32'sd0)
    // A stalled result is never dropped by the pipeline advance.
    `PVP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire

// File: verif/pvp_checker.sv
//------------------------------------------------------------------------------
// pvp_checker
// Watches the vertex and result channels, predicts each projected vertex and
// compares it field by field with what the block returns.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [30:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0]  flags;   // in_view_frustum, in_clip_box, bad_depth from bit 0
        logic [95:0] coords;  // ndc_x, ndc_y, ndc_depth from bit 0
    } vertex_out_t;

    pvp_pkg::cfg_t regs;
    vertex_out_t   projected_q[$];

    // Truncating divide of a magnitude, signed and clamped to 32 bits.
    function automatic logic signed [63:0] clamp_div(logic [63:0] mag, logic [63:0] den,
                                                     logic neg);
        logic [63:0] q;
        q = mag / den;
        if (neg)
            return (q >= 64'h8000_0000) ? -64'sh8000_0000 : -$signed(q);
        return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(q);
    endfunction

    function automatic vertex_out_t project_vertex(logic [95:0] v);
        logic signed [63:0] x, y, z, nx, ny, nd, num, one, asp, nr, fr;
        logic [63:0] mx, my, mn;
        logic inv, inc;
        vertex_out_t r;
        x = {{32{v[31]}}, v[31:0]};
        y = {{32{v[63]}}, v[63:32]};
        z = {{32{v[95]}}, v[95:64]};
        one = 64'sd1 <<< pvp_pkg::FRAC_BITS;
        asp = {33'd0, regs.aspect_ratio};
        nr = {33'd0, regs.near_plane};
        fr = {33'd0, regs.far_plane};
        r = '0;
        if (z <= 0)
        begin
            r.flags = 3'b100;
            return r;
        end
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        nx = clamp_div(mx * {33'd0, regs.x_scale}, z, x < 0);
        ny = clamp_div(my * {33'd0, regs.y_scale}, z, y < 0);
        nd = 0;
        if (fr > nr)
        begin
            num = z - nr;
            mn = (num < 0) ? -num : num;
            nd = clamp_div(mn << pvp_pkg::FRAC_BITS, fr - nr, num < 0);
        end
        inv = x > -asp && x < asp && y > -one && y < one && z > nr && z < fr;
        inc = nx > -one && nx < one && ny > -one && ny < one && nd > 0 && nd < one;
        r.coords = {nd[31:0], ny[31:0], nx[31:0]};
        r.flags = {1'b0, inc, inv};
        return r;
    endfunction

    assign pending = projected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vertex_out_t want;
        if (!rst_n)
        begin
            regs <= {31'd513320, 31'd256660, 31'd32768, 31'd65536, 31'd655360};
            projected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (pvp_pkg::reg_idx_t'(cfg_addr))
                    pvp_pkg::REG_X_SCALE:      regs.x_scale <= cfg_wdata;
                    pvp_pkg::REG_Y_SCALE:      regs.y_scale <= cfg_wdata;
                    pvp_pkg::REG_ASPECT_RATIO: regs.aspect_ratio <= cfg_wdata;
                    pvp_pkg::REG_NEAR_PLANE:   regs.near_plane <= cfg_wdata;
                    pvp_pkg::REG_FAR_PLANE:    regs.far_plane <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                projected_q.push_back(project_vertex(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (projected_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h %h",
                             $realtime, m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = projected_q.pop_front();
                    if (want.coords[31:0] !== m_tdata[31:0] ||
                        want.coords[63:32] !== m_tdata[63:32] ||
                        want.coords[95:64] !== m_tdata[95:64] ||
                        want.flags !== m_tuser)
                    begin
                        $display("%0t: mismatch: expected %h %h, actual %h %h",
                                 $realtime, want.flags, want.coords, m_tuser, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: verif/tb.sv
//------------------------------------------------------------------------------
// tb
// Drives vertices and register settings into the projection block with random
// gaps and result stalls; a checker beside the block judges every result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY = 36;
    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [30:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    int          sink_wait = 0;
    bit          flow_on = 1'b1;

    always #6 clk = ~clk;

    perspective_vertex_project_top u_dut (.*);

    pvp_checker u_chk (.*);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side stalls: a fresh stall is drawn after each transfer.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sink_wait = flow_on ? $urandom_range(0, 10) : 0;
        if (sink_wait > 0)
        begin
            m_tready <= 1'b0;
            sink_wait = sink_wait - 1;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(pvp_pkg::reg_idx_t idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Valid stays high between back-to-back transfers; it drops only for a gap.
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = flow_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return $urandom_range(0, 131072) - 65536;
            default: return $urandom_range(0, 1572864) - 786432;
        endcase
    endfunction

    function automatic logic [31:0] rand_depth();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(0, 2) == 0 ? 32'd0 : -$urandom_range(1, 100);
            default: return $urandom_range(1, 900000);
        endcase
    endfunction

    task automatic random_phase(int count);
        repeat (count)
            send_vertex(rand_coord(), rand_coord(), rand_depth());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, non-positive depth, planes and boundaries.
        send_vertex(32'd0, 32'd0, 32'd0);
        send_vertex(32'd65536, 32'd65536, 32'hFFFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'd1);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(32'd0, 32'd0, 32'd65536);
        send_vertex(32'd0, 32'd0, 32'd655360);
        send_vertex(32'd32767, 32'd65535, 32'd65537);
        send_vertex(32'd32768, -32'sd65536, 32'd131072);
        send_vertex(-32'sd32767, -32'sd65535, 32'd655359);
        send_vertex(32'd1000, -32'sd2000, 32'd300000);
        send_vertex(32'hFFFF_FFFF, 32'd1, 32'd50);
        drain();

        // Empty depth range and zero registers, then the largest values, then a minimal depth range and unit scales.
        write_reg(pvp_pkg::REG_NEAR_PLANE, 31'd655360);
        write_reg(pvp_pkg::REG_FAR_PLANE, 31'd65536);
        write_reg(pvp_pkg::REG_ASPECT_RATIO, 31'd0);
        write_reg(pvp_pkg::REG_X_SCALE, 31'd0);
        write_reg(pvp_pkg::REG_Y_SCALE, 31'd0);
        send_vertex(32'd0, 32'd0, 32'd300000);
        random_phase(150);
        drain();
        write_reg(pvp_pkg::REG_NEAR_PLANE, 31'd1);
        write_reg(pvp_pkg::REG_FAR_PLANE, 31'h7FFF_FFFF);
        write_reg(pvp_pkg::REG_ASPECT_RATIO, 31'h7FFF_FFFF);
        write_reg(pvp_pkg::REG_X_SCALE, 31'h7FFF_FFFF);
        write_reg(pvp_pkg::REG_Y_SCALE, 31'h7FFF_FFFF);
        random_phase(250);
        drain();
        write_reg(pvp_pkg::REG_NEAR_PLANE, 31'd0);
        write_reg(pvp_pkg::REG_FAR_PLANE, 31'd1);
        write_reg(pvp_pkg::REG_X_SCALE, 31'd1);
        write_reg(pvp_pkg::REG_Y_SCALE, 31'd1);
        random_phase(150);
        drain();

        // Typical camera settings with random content.
        repeat (6)
        begin
            write_reg(pvp_pkg::REG_X_SCALE, 31'($urandom_range(20000, 600000)));
            write_reg(pvp_pkg::REG_Y_SCALE, 31'($urandom_range(20000, 600000)));
            write_reg(pvp_pkg::REG_ASPECT_RATIO, 31'($urandom_range(1, 200000)));
            write_reg(pvp_pkg::REG_NEAR_PLANE, 31'($urandom_range(1, 100000)));
            write_reg(pvp_pkg::REG_FAR_PLANE, 31'($urandom_range(100000, 1000000)));
            flow_on = $urandom_range(0, 3) != 0;
            random_phase(190);
            drain();
        end
        flow_on = 1'b1;

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/pvp_pkg.sv
design/pvp_front.sv
design/pvp_div_cell.sv
design/pvp_back.sv
design/perspective_vertex_project_top.sv
verif/pvp_checker.sv
verif/tb.sv
